// ===== sv/dead_reckoning_velocity_xy_macros.svh =====
// assertion macros for the planar velocity block
// used by the port checker, no other dependencies
`ifndef DEAD_RECKONING_VELOCITY_XY_MACROS_SVH
`define DEAD_RECKONING_VELOCITY_XY_MACROS_SVH

// same-cycle implication, disabled during reset
`define DRV_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define DRV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/drv_pkg.sv =====
// shared types, constants and functions of the planar velocity block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package drv_pkg;

  localparam int InW      = 16;
  localparam int OutW     = 24;
  localparam int GainW    = 16;
  localparam int SumW     = 18;
  localparam int AngW     = 32;
  localparam int XW       = 36;
  localparam int ZW       = 34;
  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 16;

  localparam int CordicSteps = 16;
  localparam int AtanEntries = 30;
  localparam int AtanIdxW    = 5;
  localparam int NumIter     = (CordicSteps < AtanEntries) ? CordicSteps : AtanEntries;
  localparam int IterW       = $clog2(NumIter);

  localparam int QueueDepth = 2;

  localparam logic [29:0] GainQ30 = 30'd652032874;
  localparam logic signed [XW-1:0] OutMax = XW'(64'sd8388607);
  localparam logic signed [XW-1:0] OutMin = XW'(-64'sd8388608);
  localparam logic signed [XW-1:0] RoundHalf = XW'(64'sd32768);

  localparam logic [CfgIdxW-1:0] RegSpeedGain   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegHeadingGain = CfgIdxW'(1);

  typedef struct packed {
    logic signed [XW-1:0] x0;
    logic signed [ZW-1:0] z;
  } drv_item_t;

  function automatic logic [AngW-1:0] atan_entry(input logic [AtanIdxW-1:0] idx);
    logic [AngW-1:0] r;
    unique case (idx)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051D;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2E;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2F9;
      5'd15: r = 32'h0000517C;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A2F;
      5'd19: r = 32'h00000517;
      5'd20: r = 32'h0000028B;
      5'd21: r = 32'h00000145;
      5'd22: r = 32'h000000A2;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000028;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000002;
      5'd29: r = 32'h00000001;
      default: r = '0;
    endcase
    return r;
  endfunction

  // round half up, drop 16 fraction bits, clamp to output range
  function automatic logic [OutW-1:0] finish(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] r;
    r = (v + RoundHalf) >>> 16;
    if (r > OutMax) begin
      r = OutMax;
    end else if (r < OutMin) begin
      r = OutMin;
    end
    return r[OutW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/dead_reckoning_velocity_xy.sv =====
// the iterative rotation unit runs 16 rotation steps per sample and sets the throughput;
// it takes a new sample only once the last result is in the output register;
// the front end takes a new sample only while idle, into a two-word queue
// reset: asynchronous active low, clears gains, heading, queue and all valid state
// top level: front end, queue and rotation unit; depends on drv_pkg
`timescale 1ns / 1ps
`default_nettype none

module dead_reckoning_velocity_xy import drv_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxW-1:0]     cfg_index_i,
  input  logic [CfgDataW-1:0]    cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic signed [InW-1:0]  speed_front_left_i,
  input  logic signed [InW-1:0]  speed_rear_left_i,
  input  logic signed [InW-1:0]  speed_front_right_i,
  input  logic signed [InW-1:0]  speed_rear_right_i,
  input  logic signed [InW-1:0]  yaw_rate_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [OutW-1:0] velocity_x_o,
  output logic signed [OutW-1:0] velocity_y_o
);

  logic      fr_valid, fr_ready, bk_valid, bk_ready;
  drv_item_t fr_item, bk_item;

  assign cfg_ready_o = 1'b1;

  drv_front u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .speed_front_left_i  (speed_front_left_i),
    .speed_rear_left_i   (speed_rear_left_i),
    .speed_front_right_i (speed_front_right_i),
    .speed_rear_right_i  (speed_rear_right_i),
    .yaw_rate_i          (yaw_rate_i),
    .item_valid_o        (fr_valid),
    .item_ready_i        (fr_ready),
    .item_o              (fr_item)
  );

  drv_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_item_i  (fr_item),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_item_o   (bk_item)
  );

  drv_cordic u_cordic (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (bk_valid),
    .item_ready_o (bk_ready),
    .item_i       (bk_item),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .velocity_x_o (velocity_x_o),
    .velocity_y_o (velocity_y_o)
  );

endmodule

`default_nettype wire

// ===== sv/drv_front.sv =====
// front end: accepts samples, holds gains and heading, builds the rotation start word
// depends on drv_pkg
`timescale 1ns / 1ps
`default_nettype none

module drv_front import drv_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  input  logic [CfgIdxW-1:0]         cfg_index_i,
  input  logic [CfgDataW-1:0]        cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [InW-1:0]      speed_front_left_i,
  input  logic signed [InW-1:0]      speed_rear_left_i,
  input  logic signed [InW-1:0]      speed_front_right_i,
  input  logic signed [InW-1:0]      speed_rear_right_i,
  input  logic signed [InW-1:0]      yaw_rate_i,
  output logic                       item_valid_o,
  input  logic                       item_ready_i,
  output drv_item_t                  item_o
);

  localparam logic [1:0] FrIdle = 2'd0;
  localparam logic [1:0] FrMulV = 2'd1;
  localparam logic [1:0] FrMulK = 2'd2;
  localparam logic [1:0] FrPush = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [GainW-1:0]       speed_gain_q, heading_gain_q;
  logic [AngW-1:0]        heading_q, heading_d;
  logic signed [SumW-1:0] sum_q, sum_d;
  logic [AngW-1:0]        hinc_q, hinc_d;
  logic signed [SumW-1:0] v_q, v_d;
  drv_item_t              item_q, item_d;

  logic signed [AngW:0]      hprod;
  logic signed [SumW+GainW:0] vprod;
  logic signed [SumW+30:0]   kprod;
  logic signed [XW-1:0]      x0;
  logic                      fold;
  logic [AngW-1:0]           ang;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_gain_q   <= '0;
      heading_gain_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == RegSpeedGain) begin
        speed_gain_q <= cfg_data_i[GainW-1:0];
      end else if (cfg_index_i == RegHeadingGain) begin
        heading_gain_q <= cfg_data_i[GainW-1:0];
      end
    end
  end

  assign hprod = yaw_rate_i * $signed({1'b0, heading_gain_q});
  assign vprod = sum_q * $signed({1'b0, speed_gain_q});
  assign kprod = v_q * $signed({1'b0, GainQ30});
  assign x0    = XW'($signed(kprod[SumW+29:14]));
  // heading in the left half-plane: negate and turn by half a turn
  assign fold  = heading_q[AngW-1] ^ heading_q[AngW-2];
  assign ang   = {heading_q[AngW-1] ^ fold, heading_q[AngW-2:0]};

  always_comb begin
    state_d   = state_q;
    heading_d = heading_q;
    sum_d     = sum_q;
    hinc_d    = hinc_q;
    v_d       = v_q;
    item_d    = item_q;
    unique case (state_q)
      FrIdle: begin
        if (in_valid_i) begin
          sum_d = SumW'(speed_front_left_i) + SumW'(speed_rear_left_i)
                + SumW'(speed_front_right_i) + SumW'(speed_rear_right_i);
          hinc_d  = hprod[AngW-1:0];
          state_d = FrMulV;
        end
      end
      FrMulV: begin
        v_d       = vprod[SumW+GainW-1:GainW];
        heading_d = heading_q + hinc_q;
        state_d   = FrMulK;
      end
      FrMulK: begin
        item_d.x0 = fold ? -x0 : x0;
        item_d.z  = ZW'($signed(ang));
        state_d   = FrPush;
      end
      FrPush: begin
        if (item_ready_i) begin
          state_d = FrIdle;
        end
      end
      default: state_d = FrIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= FrIdle;
      heading_q <= '0;
    end else begin
      state_q   <= state_d;
      heading_q <= heading_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    hinc_q <= hinc_d;
    v_q    <= v_d;
    item_q <= item_d;
  end

  assign in_stall_o   = (state_q != FrIdle);
  assign item_valid_o = (state_q == FrPush);
  assign item_o       = item_q;

endmodule

`default_nettype wire

// ===== sv/drv_queue.sv =====
// short word queue between front end and rotation unit
// depends on drv_pkg
`timescale 1ns / 1ps
`default_nettype none

module drv_queue import drv_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  output logic      push_ready_o,
  input  drv_item_t push_item_i,
  output logic      pop_valid_o,
  input  logic      pop_ready_i,
  output drv_item_t pop_item_o
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QueueDepth);

  drv_item_t       mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  assign push_ready_o = (count_q != CntFull);
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CntW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/drv_cordic.sv =====
// back end: iterative rotation, rounding, saturation and output register
// depends on drv_pkg
`timescale 1ns / 1ps
`default_nettype none

module drv_cordic import drv_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   item_valid_i,
  output logic                   item_ready_o,
  input  drv_item_t              item_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [OutW-1:0] velocity_x_o,
  output logic signed [OutW-1:0] velocity_y_o
);

  localparam logic [1:0] BkIdle = 2'd0;
  localparam logic [1:0] BkRun  = 2'd1;
  localparam logic [1:0] BkDone = 2'd2;
  localparam logic [IterW-1:0] IterLast = IterW'(NumIter - 1);

  logic [1:0]            state_q, state_d;
  logic [IterW-1:0]      iter_q, iter_d;
  logic signed [XW-1:0]  x_q, x_d, y_q, y_d;
  logic signed [ZW-1:0]  z_q, z_d;
  logic                  out_valid_q, out_valid_d;
  logic [OutW-1:0]       vx_q, vy_q;
  logic                  load_out;

  logic signed [XW-1:0]  dx, dy;
  logic signed [ZW-1:0]  da;

  assign dx = y_q >>> iter_q;
  assign dy = x_q >>> iter_q;
  assign da = $signed({{(ZW-AngW){1'b0}}, atan_entry(AtanIdxW'(iter_q))});

  assign load_out = (state_q == BkDone) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    iter_d  = iter_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    unique case (state_q)
      BkIdle: begin
        if (item_valid_i) begin
          x_d     = item_i.x0;
          y_d     = '0;
          z_d     = item_i.z;
          iter_d  = '0;
          state_d = BkRun;
        end
      end
      BkRun: begin
        if (!z_q[ZW-1]) begin
          x_d = x_q - dx;
          y_d = y_q + dy;
          z_d = z_q - da;
        end else begin
          x_d = x_q + dx;
          y_d = y_q - dy;
          z_d = z_q + da;
        end
        if (iter_q == IterLast) begin
          state_d = BkDone;
        end else begin
          iter_d = iter_q + IterW'(1);
        end
      end
      BkDone: begin
        if (load_out) begin
          state_d = BkIdle;
        end
      end
      default: state_d = BkIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    priority if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    iter_q <= iter_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    if (load_out) begin
      vx_q <= finish(x_q);
      vy_q <= finish(y_q);
    end
  end

  assign item_ready_o = (state_q == BkIdle);
  assign out_valid_o  = out_valid_q;
  assign velocity_x_o = $signed(vx_q);
  assign velocity_y_o = $signed(vy_q);

endmodule

`default_nettype wire

// ===== sv/drv_checker.sv =====
// port-level checks of the planar velocity block, bound to the top level
// depends on drv_pkg and dead_reckoning_velocity_xy_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "dead_reckoning_velocity_xy_macros.svh"

module drv_checker import drv_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic                   cfg_valid_i,
  input logic                   cfg_ready_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic signed [OutW-1:0] velocity_x_o,
  input logic signed [OutW-1:0] velocity_y_o
);

  localparam logic signed [OutW-1:0] VelBound = OutW'(140000);

  logic [2*OutW-1:0] vel_word;
  logic              vel_in_range;

  assign vel_word     = {velocity_x_o, velocity_y_o};
  assign vel_in_range = (velocity_x_o <= VelBound) && (velocity_x_o >= -VelBound)
                     && (velocity_y_o <= VelBound) && (velocity_y_o >= -VelBound);

  `DRV_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(vel_word))
  `DRV_ASSERT_NEXT(a_front_busy, in_valid_i && !in_stall_o, in_stall_o)
  `DRV_ASSERT_IMPL(a_cfg_ready, cfg_valid_i, cfg_ready_o)
  `DRV_ASSERT_IMPL(a_vel_range, out_valid_o, vel_in_range)

endmodule

bind dead_reckoning_velocity_xy drv_checker u_checker (.*);

`default_nettype wire
